// File: rtl/sfpl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted free page list allocator: shared package
// Widths, codes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package sfpl_pkg;

   localparam int MAX_PAGES = 1024;
   localparam int PAGE_W    = 10;
   localparam int COUNT_W   = $clog2(MAX_PAGES) + 1;
   localparam int SUM_W     = COUNT_W + 1;

   localparam logic [COUNT_W-1:0] MAX_PAGES_CNT = COUNT_W'(MAX_PAGES);

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_BAD  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC_RD,
      ST_ALLOC_WB,
      ST_WALK,
      ST_CHECK,
      ST_INS_NEW,
      ST_INS_LINK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic alloc_ext;
      logic pop_rd;
      logic pop_wb;
      logic walk_start;
      logic walk_step;
      logic set_query;
      logic set_bad;
      logic ins_new;
      logic ins_link;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    head_nz;
      logic    walk_done;
      logic    free_bad;
      logic    out_free;
   } dpath_sts_type;

endpackage

// File: rtl/sfpl_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted free page list allocator: controller
// Sequences allocate, list walk, insert and response for one request at a
// time.
// ----------------------------------------------------------------------------
module sfpl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sfpl_pkg::dpath_sts_type sts,
   output sfpl_pkg::ctrl_cmd_type  cmd
);

   sfpl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfpl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         sfpl_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sfpl_pkg::ST_DISPATCH;
            end
         end
         sfpl_pkg::ST_DISPATCH: begin
            case (sts.cmd)
               sfpl_pkg::CMD_ALLOC: begin
                  if (sts.head_nz) begin
                     state_in = sfpl_pkg::ST_ALLOC_RD;
                  end else begin
                     cmd.alloc_ext = 1'b1;
                     state_in      = sfpl_pkg::ST_RESP;
                  end
               end
               sfpl_pkg::CMD_FREE, sfpl_pkg::CMD_QUERY: begin
                  cmd.walk_start = 1'b1;
                  state_in       = sfpl_pkg::ST_WALK;
               end
               default: begin
                  state_in = sfpl_pkg::ST_RESP;
               end
            endcase
         end
         sfpl_pkg::ST_ALLOC_RD: begin
            cmd.pop_rd = 1'b1;
            state_in   = sfpl_pkg::ST_ALLOC_WB;
         end
         sfpl_pkg::ST_ALLOC_WB: begin
            cmd.pop_wb = 1'b1;
            state_in   = sfpl_pkg::ST_RESP;
         end
         sfpl_pkg::ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_done) begin
               if (sts.cmd == sfpl_pkg::CMD_QUERY) begin
                  cmd.set_query = 1'b1;
                  state_in      = sfpl_pkg::ST_RESP;
               end else begin
                  state_in = sfpl_pkg::ST_CHECK;
               end
            end
         end
         sfpl_pkg::ST_CHECK: begin
            if (sts.free_bad) begin
               cmd.set_bad = 1'b1;
               state_in    = sfpl_pkg::ST_RESP;
            end else begin
               state_in = sfpl_pkg::ST_INS_NEW;
            end
         end
         sfpl_pkg::ST_INS_NEW: begin
            cmd.ins_new = 1'b1;
            state_in    = sfpl_pkg::ST_INS_LINK;
         end
         sfpl_pkg::ST_INS_LINK: begin
            cmd.ins_link = 1'b1;
            state_in     = sfpl_pkg::ST_RESP;
         end
         sfpl_pkg::ST_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = sfpl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfpl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/sfpl_dpath.sv
// ----------------------------------------------------------------------------
// Sorted free page list allocator: datapath
// Holds the link memory, list head, page count, the list walker and the
// response register.
// ----------------------------------------------------------------------------
module sfpl_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_cmd,
   input  logic [sfpl_pkg::PAGE_W-1:0]   req_page_number,
   input  sfpl_pkg::ctrl_cmd_type        cmd,
   output sfpl_pkg::dpath_sts_type       sts,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sfpl_pkg::PAGE_W-1:0]   rsp_granted_page,
   output logic                          rsp_is_free,
   output logic [1:0]                    rsp_status
);

   localparam int PW = sfpl_pkg::PAGE_W;
   localparam int CW = sfpl_pkg::COUNT_W;
   localparam int SW = sfpl_pkg::SUM_W;

   logic [PW-1:0] link_mem [sfpl_pkg::MAX_PAGES];
   logic [PW-1:0] rd_addr;
   logic [PW-1:0] rd_data_ff;
   logic          mem_we;
   logic [PW-1:0] mem_waddr;
   logic [PW-1:0] mem_wdata;

   logic [PW-1:0] head_ff;
   logic [CW-1:0] count_ff;

   sfpl_pkg::cmd_type op_ff;
   logic [PW-1:0]     page_ff;

   logic          first_ff;
   logic          pred_hit_ff;
   logic [PW-1:0] pred_ff;
   logic [PW-1:0] succ_ff;
   logic          found_ff;
   logic [CW-1:0] len_ff;
   logic [CW-1:0] steps_ff;

   logic [PW-1:0] res_granted_ff;
   logic          res_is_free_ff;
   logic [1:0]    res_status_ff;

   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_granted_ff;
   logic          rsp_is_free_ff;
   logic [1:0]    rsp_status_ff;

   logic [PW-1:0] cur;
   logic          walk_done;
   logic [SW-1:0] extent;

   assign cur       = first_ff ? head_ff : rd_data_ff;
   assign walk_done = (cur == '0) || (CW'(cur) >= sfpl_pkg::MAX_PAGES_CNT)
                      || (steps_ff == sfpl_pkg::MAX_PAGES_CNT);
   assign extent    = SW'(count_ff) + SW'(len_ff);

   always_comb begin
      rd_addr   = cur;
      mem_we    = 1'b0;
      mem_waddr = page_ff;
      mem_wdata = (pred_ff == '0) ? head_ff : succ_ff;
      if (cmd.pop_rd) begin
         rd_addr = head_ff;
      end
      if (cmd.ins_new) begin
         mem_we = 1'b1;
      end
      if (cmd.ins_link && (pred_ff != '0)) begin
         mem_we    = 1'b1;
         mem_waddr = pred_ff;
         mem_wdata = page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= CW'(1);
      end else begin
         if (cmd.pop_wb) begin
            head_ff  <= rd_data_ff;
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.alloc_ext && (count_ff < sfpl_pkg::MAX_PAGES_CNT)) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.ins_link) begin
            if (pred_ff == '0) begin
               head_ff <= page_ff;
            end
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff          <= sfpl_pkg::cmd_type'(req_cmd);
         page_ff        <= req_page_number;
         res_granted_ff <= '0;
         res_is_free_ff <= 1'b0;
         res_status_ff  <= sfpl_pkg::STATUS_OK;
      end
      if (cmd.alloc_ext) begin
         if (count_ff >= sfpl_pkg::MAX_PAGES_CNT) begin
            res_status_ff <= sfpl_pkg::STATUS_FULL;
         end else begin
            res_granted_ff <= count_ff[PW-1:0];
         end
      end
      if (cmd.pop_rd) begin
         res_granted_ff <= head_ff;
      end
      if (cmd.set_query) begin
         res_is_free_ff <= found_ff;
      end
      if (cmd.set_bad) begin
         res_status_ff <= sfpl_pkg::STATUS_BAD;
      end
      if (cmd.walk_start) begin
         first_ff    <= 1'b1;
         pred_hit_ff <= 1'b0;
         pred_ff     <= '0;
         found_ff    <= 1'b0;
         len_ff      <= '0;
         steps_ff    <= '0;
      end
      if (cmd.walk_step) begin
         if (pred_hit_ff && !first_ff) begin
            succ_ff <= cur;
         end
         if (!walk_done) begin
            first_ff    <= 1'b0;
            pred_hit_ff <= (cur < page_ff);
            if (cur < page_ff) begin
               pred_ff <= cur;
            end
            if (cur == page_ff) begin
               found_ff <= 1'b1;
            end
            len_ff   <= len_ff + CW'(1);
            steps_ff <= steps_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_is_free_ff <= res_is_free_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   assign sts.cmd       = op_ff;
   assign sts.head_nz   = (head_ff != '0) && (CW'(head_ff) < sfpl_pkg::MAX_PAGES_CNT);
   assign sts.walk_done = walk_done;
   assign sts.free_bad  = (page_ff == '0)
                          || (CW'(page_ff) >= sfpl_pkg::MAX_PAGES_CNT)
                          || (SW'(page_ff) >= extent)
                          || found_ff
                          || (count_ff <= CW'(1));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_page = rsp_granted_ff;
   assign rsp_is_free      = rsp_is_free_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// File: rtl/sorted_free_page_list_allocator_top.sv
// ----------------------------------------------------------------------------
// Sorted free page list allocator: top level
// Page allocator with a free list kept in ascending page order.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_cmd, req_page_number
//   rsp      out        rsp_valid / rsp_stall  rsp_granted_page, rsp_is_free,
//                                              rsp_status
//
// One request is in work at a time. Allocate either extends the store or pops
// the list head; free and query first walk the list, so their time grows
// with the list length, set by the walk over the link memory at one read per
// cycle. The link memory is not cleared at reset; the list head is cleared
// and the page count is set to one. A stalled response holds in the output
// register while the controller waits to load the next one.
// ----------------------------------------------------------------------------
module sorted_free_page_list_allocator_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [sfpl_pkg::PAGE_W-1:0] req_page_number,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sfpl_pkg::PAGE_W-1:0] rsp_granted_page,
   output logic                        rsp_is_free,
   output logic [1:0]                  rsp_status
);

   sfpl_pkg::ctrl_cmd_type  cmd;
   sfpl_pkg::dpath_sts_type sts;

   sfpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sfpl_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_page_number  (req_page_number),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_page (rsp_granted_page),
      .rsp_is_free      (rsp_is_free),
      .rsp_status       (rsp_status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one still in work");

   a_full_grants_nothing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == sfpl_pkg::STATUS_FULL)) |-> (rsp_granted_page == '0))
      else $error("store full response carries a page");

   a_free_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_free) |->
      ((rsp_status == sfpl_pkg::STATUS_OK) && (rsp_granted_page == '0)))
      else $error("query answer combined with grant or error");

endmodule

// File: tb/sfpl_checker.sv
// ----------------------------------------------------------------------------
// Sorted free page list allocator: response checker
// Watches both channels and keeps its own copy of the free list, the list
// head and the page count. Every accepted request is turned into the
// expected response, and every accepted response is compared field by field
// with the oldest expected one. The number of failures and the number of
// outstanding responses are handed to the testbench top.
// ----------------------------------------------------------------------------
module sfpl_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [sfpl_pkg::PAGE_W-1:0] req_page_number,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [sfpl_pkg::PAGE_W-1:0] rsp_granted_page,
   input  logic                        rsp_is_free,
   input  logic [1:0]                  rsp_status,
   output int                          fail_count,
   output int                          pending
);

   localparam int PW = sfpl_pkg::PAGE_W;
   localparam int CW = sfpl_pkg::COUNT_W;

   typedef struct packed {
      logic [PW-1:0]        granted;
      logic                 is_free;
      sfpl_pkg::status_type status;
   } page_answer_type;

   logic [PW-1:0]   page_link [sfpl_pkg::MAX_PAGES];
   logic [PW-1:0]   free_head;
   logic [CW-1:0]   used_pages;
   page_answer_type answers_due [$];
   int              fails;

   function automatic void scan_free_list(input logic [PW-1:0] page, output int len,
                                          output bit found, output logic [PW-1:0] pred);
      logic [PW-1:0] cur;
      int steps;
      cur   = free_head;
      len   = 0;
      found = 1'b0;
      pred  = '0;
      steps = 0;
      while (cur != '0 && steps < sfpl_pkg::MAX_PAGES) begin
         if (cur < page) pred = cur;
         if (cur == page) found = 1'b1;
         len++;
         cur = page_link[cur];
         steps++;
      end
   endfunction

   task automatic apply_page_command(input sfpl_pkg::cmd_type cmd,
                                     input logic [PW-1:0] page,
                                     output page_answer_type ans);
      int len;
      bit found;
      logic [PW-1:0] pred;
      ans = '{granted: '0, is_free: 1'b0, status: sfpl_pkg::STATUS_OK};
      case (cmd)
         sfpl_pkg::CMD_ALLOC: begin
            if (free_head != '0) begin
               ans.granted = free_head;
               free_head   = page_link[free_head];
               used_pages++;
            end else if (used_pages >= sfpl_pkg::MAX_PAGES_CNT) begin
               ans.status = sfpl_pkg::STATUS_FULL;
            end else begin
               ans.granted = used_pages[PW-1:0];
               used_pages++;
            end
         end
         sfpl_pkg::CMD_FREE: begin
            scan_free_list(page, len, found, pred);
            if (page == '0 || int'(page) >= int'(used_pages) + len || found ||
                used_pages <= CW'(1)) begin
               ans.status = sfpl_pkg::STATUS_BAD;
            end else begin
               if (pred == '0) begin
                  page_link[page] = free_head;
                  free_head       = page;
               end else begin
                  page_link[page] = page_link[pred];
                  page_link[pred] = page;
               end
               used_pages--;
            end
         end
         sfpl_pkg::CMD_QUERY: begin
            if (page != '0) begin
               scan_free_list(page, len, found, pred);
               ans.is_free = found;
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      page_answer_type want;
      if (reset) begin
         free_head  = '0;
         used_pages = CW'(1);
         answers_due.delete();
         fails = 0;
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual granted_page %0d",
                        $time, rsp_granted_page, " is_free %0d status %0d",
                        rsp_is_free, rsp_status);
               fails++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_granted_page !== want.granted) begin
                  $display("%0t: granted_page mismatch: expected %0d, actual %0d",
                           $time, want.granted, rsp_granted_page);
                  fails++;
               end
               if (rsp_is_free !== want.is_free) begin
                  $display("%0t: is_free mismatch: expected %0d, actual %0d",
                           $time, want.is_free, rsp_is_free);
                  fails++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_page_command(sfpl_pkg::cmd_type'(req_cmd), req_page_number, want);
            answers_due.push_back(want);
         end
         pending    <= answers_due.size();
         fail_count <= fails;
      end
   end

endmodule

// File: tb/sorted_free_page_list_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// Sorted free page list allocator: testbench top
// Drives allocate, free and query requests into the allocator: a directed
// opening over the edge cases, random traffic in randomly chosen
// allocate-heavy, balanced and free-heavy stretches under three idling
// patterns, and a long response hold-off. The checker beside the block
// predicts and compares every response.
// ----------------------------------------------------------------------------
module sorted_free_page_list_allocator_top_tb;

   localparam int PW = sfpl_pkg::PAGE_W;

   logic          clock           = 1'b0;
   logic          reset           = 1'b1;
   logic          req_valid       = 1'b0;
   logic          req_stall;
   logic [1:0]    req_cmd         = sfpl_pkg::CMD_ALLOC;
   logic [PW-1:0] req_page_number = '0;
   logic          rsp_valid;
   logic          rsp_stall       = 1'b0;
   logic [PW-1:0] rsp_granted_page;
   logic          rsp_is_free;
   logic [1:0]    rsp_status;

   int fail_count;
   int pending;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_ticket  = 0;
   int hold_served  = 0;
   int hold_left    = 0;

   sorted_free_page_list_allocator_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_page (rsp_granted_page),
      .rsp_is_free      (rsp_is_free),
      .rsp_status       (rsp_status)
   );

   sfpl_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_page (rsp_granted_page),
      .rsp_is_free      (rsp_is_free),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_ticket) begin
         hold_served <= hold_ticket;
         hold_left   <= 300;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   task automatic send_request(input sfpl_pkg::cmd_type cmd, input logic [PW-1:0] page);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_page_number <= page;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_all_answered();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   task automatic random_page_traffic(input int count);
      int i;
      int roll;
      int alloc_pct;
      sfpl_pkg::cmd_type cmd;
      logic [PW-1:0] page;
      alloc_pct = 45;
      for (i = 0; i < count; i++) begin
         // Each 24 requests, pick an alloc-heavy, balanced or free-heavy mix.
         if (i % 24 == 0) begin
            case ($urandom_range(0, 2))
               0:       alloc_pct = 20;
               1:       alloc_pct = 45;
               default: alloc_pct = 70;
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < alloc_pct) cmd = sfpl_pkg::CMD_ALLOC;
         else if (roll < alloc_pct + (100 - alloc_pct) * 6 / 10) cmd = sfpl_pkg::CMD_FREE;
         else if (roll < 97) cmd = sfpl_pkg::CMD_QUERY;
         else cmd = sfpl_pkg::CMD_NONE;
         roll = $urandom_range(0, 99);
         if (roll < 80) page = PW'($urandom_range(1, 64));
         else if (roll < 86) page = '0;
         else if (roll < 92) page = PW'($urandom_range(1020, 1023));
         else page = PW'($urandom);
         send_request(cmd, page);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      send_request(sfpl_pkg::CMD_ALLOC, 10'd1023);
      send_request(sfpl_pkg::CMD_QUERY, 10'd0);
      send_request(sfpl_pkg::CMD_QUERY, 10'd1023);
      send_request(sfpl_pkg::CMD_QUERY, 10'd1);
      send_request(sfpl_pkg::CMD_FREE, 10'd0);
      send_request(sfpl_pkg::CMD_FREE, 10'd1023);
      send_request(sfpl_pkg::CMD_FREE, 10'd5);
      send_request(sfpl_pkg::CMD_FREE, 10'd1);
      send_request(sfpl_pkg::CMD_FREE, 10'd1);
      send_request(sfpl_pkg::CMD_QUERY, 10'd1);
      send_request(sfpl_pkg::CMD_NONE, 10'd1023);
      repeat (5) send_request(sfpl_pkg::CMD_ALLOC, 10'd0);
      send_request(sfpl_pkg::CMD_FREE, 10'd4);
      send_request(sfpl_pkg::CMD_FREE, 10'd2);
      send_request(sfpl_pkg::CMD_FREE, 10'd5);
      send_request(sfpl_pkg::CMD_FREE, 10'd3);
      send_request(sfpl_pkg::CMD_QUERY, 10'd5);
      send_request(sfpl_pkg::CMD_QUERY, 10'd3);
      send_request(sfpl_pkg::CMD_FREE, 10'd1);
      send_request(sfpl_pkg::CMD_ALLOC, 10'd512);
      wait_all_answered();

      set_idling(16, 55);
      random_page_traffic(180);

      // The receiver holds off long enough for the request side to back up.
      hold_ticket <= hold_ticket + 1;
      random_page_traffic(12);
      wait_all_answered();

      set_idling(55, 16);
      random_page_traffic(180);

      set_idling(0, 0);
      random_page_traffic(180);

      wait_all_answered();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
